### src/ppt_pkg.sv
package ppt_pkg;

  localparam int PageBits = 20;
  localparam int CntBits  = PageBits + 1;
  localparam int TablePages = 1 << PageBits;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_BAD_RANGE   = 4'd1,
    ST_NO_SPACE    = 4'd2,
    ST_OVERLAP     = 4'd3,
    ST_NOT_PRESENT = 4'd4,
    ST_GUARD       = 4'd5,
    ST_READ_VIOL   = 4'd6,
    ST_WRITE_VIOL  = 4'd7,
    ST_EXEC_VIOL   = 4'd8,
    ST_NONE_FREED  = 4'd9
  } status_t;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_PROTECT = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;
  localparam logic [2:0] OP_FETCH   = 3'd5;
  localparam logic [2:0] OP_QUERY   = 3'd6;

  localparam logic [1:0] REG_PAGE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_SEARCH_START = 2'd1;
  localparam logic [1:0] REG_SEARCH_END   = 2'd2;

  localparam int B_PRESENT  = 4;
  localparam int B_DIRTY    = 5;
  localparam int B_ACCESSED = 6;

  typedef struct packed {
    logic [2:0]          op;
    logic [PageBits-1:0] start_page;
    logic [CntBits-1:0]  page_count;
    logic [3:0]          prot;
  } req_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [PageBits-1:0] base_page;
    logic [CntBits-1:0]  pages_done;
    logic [3:0]          prot_out;
    logic                is_present;
    logic                written_then_executed;
    logic [CntBits-1:0]  pages_in_use;
  } rsp_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;       // capture request, set walk pointer to range start
    logic load_win;   // set walk pointer to search window start
    logic rd;         // read entry at walk pointer
    logic step;       // advance walk pointer and counters using read data
    logic wr_back;    // write entry at walk pointer from read data
    logic ptr_base;   // set walk pointer to base
    logic alloc_wr;   // write new allocated entry, advance pointer
    logic commit;     // update allocated count, build response
    logic reset_run;  // zero counters
    logic mem_clr;    // clearing pass write
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       range_ok;
    logic       start_zero;
    logic       cnt_zero;
    logic       quota_fail;
    logic       win_empty;
    logic       win_last;    // walk pointer at last page of window
    logic       cnt_last;    // this is the last page of the range
    logic       present;     // read data present bit
    logic       guard;       // read data guard bit
    logic       fault;       // check fault on read data
    logic       run_hit;     // run length reaches page_count
    logic       done_zero;
    logic       alloc_last;
    logic       clr_last;
  } sts_t;

endpackage

### src/ppt_datapath.sv
module ppt_datapath
  import ppt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CntBits-1:0]  cfg_data,
  input  req_t                req,
  input  cmd_t                cmd,
  input  logic [3:0]          res_status,
  output sts_t                sts,
  output rsp_t                rsp
);

  logic [6:0]          mem [TablePages];
  logic [6:0]          rdata;
  logic [PageBits-1:0] ptr;
  logic [PageBits:0]   wptr;
  logic [CntBits-1:0]  idx;
  logic [CntBits-1:0]  run;
  logic [CntBits-1:0]  done;
  logic [CntBits-1:0]  used;
  logic [CntBits-1:0]  used_next;
  logic [CntBits-1:0]  page_limit;
  logic [CntBits-1:0]  search_start;
  logic [CntBits-1:0]  search_end;
  logic [CntBits-1:0]  win_end;
  logic [CntBits-1:0]  avail;
  logic [PageBits+1:0] range_end;
  logic [PageBits-1:0] base;
  logic [PageBits-1:0] hit_base;
  logic [PageBits-1:0] base_ptr;
  logic                auto_alloc;
  req_t                r;
  rsp_t                rsp_next;
  logic [3:0]          need;
  logic                fault;
  logic [6:0]          wb_data;
  logic                mem_we;
  logic [PageBits-1:0] mem_addr;
  logic [6:0]          mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit   <= CntBits'(TablePages);
      search_start <= CntBits'(65536);
      search_end   <= CntBits'(524288);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAGE_LIMIT:   page_limit   <= cfg_data;
        REG_SEARCH_START: search_start <= cfg_data;
        REG_SEARCH_END:   search_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign win_end    = (search_end > CntBits'(TablePages)) ? CntBits'(TablePages) : search_end;
  assign avail      = (page_limit > used) ? page_limit - used : '0;
  assign range_end  = {2'b00, r.start_page} + {1'b0, r.page_count};
  assign need       = (r.op == OP_READ) ? 4'b0001 : (r.op == OP_WRITE) ? 4'b0010 : 4'b0100;
  assign fault      = !rdata[B_PRESENT] || rdata[3] || ((rdata[3:0] & need) == 4'b0);
  assign auto_alloc = (r.op == OP_ALLOC) && (r.start_page == '0);
  assign hit_base   = PageBits'(wptr[PageBits-1:0] + 1'b1 - r.page_count[PageBits-1:0]);
  assign base_ptr   = auto_alloc ? hit_base : base;

  always_comb begin
    wb_data = rdata;
    case (r.op)
      OP_FREE:    wb_data = '0;
      OP_PROTECT: wb_data = {rdata[6:4], r.prot};
      OP_WRITE:   wb_data = rdata | 7'h60;
      OP_FETCH:   wb_data = rdata | 7'h40;
      default:    wb_data = rdata;
    endcase
  end

  always_comb begin
    mem_we    = cmd.wr_back || cmd.alloc_wr || cmd.mem_clr;
    mem_addr  = ptr;
    mem_wdata = cmd.mem_clr ? 7'h00 : cmd.alloc_wr ? {3'b001, r.prot} : wb_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd) rdata <= mem[ptr];
  end

  always_comb begin
    rsp_next        = '0;
    used_next       = used;
    rsp_next.status = res_status;
    case (r.op)
      OP_ALLOC: begin
        if (res_status == ST_OK) begin
          rsp_next.base_page  = base;
          rsp_next.pages_done = r.page_count;
          used_next           = used + r.page_count;
        end
      end
      OP_FREE: begin
        if (res_status != ST_BAD_RANGE) begin
          rsp_next.pages_done = done;
          used_next           = (used >= done) ? used - done : '0;
        end
      end
      OP_PROTECT: begin
        if (res_status == ST_OK) rsp_next.pages_done = r.page_count;
      end
      OP_READ, OP_WRITE, OP_FETCH: rsp_next.pages_done = done;
      OP_QUERY: begin
        if (res_status == ST_OK) begin
          rsp_next.is_present = rdata[B_PRESENT];
          rsp_next.prot_out   = rdata[B_PRESENT] ? rdata[3:0] : 4'b0;
          rsp_next.written_then_executed = rdata[B_DIRTY] && rdata[B_ACCESSED] && rdata[2];
        end
      end
      default: ;
    endcase
    rsp_next.pages_in_use = used_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      ptr  <= '0;
      idx  <= '0;
      run  <= '0;
      done <= '0;
      base <= '0;
      wptr <= '0;
      rsp  <= '0;
      r    <= '0;
    end else begin
      if (cmd.load) r <= req;

      if (cmd.load) ptr <= req.start_page;
      else if (cmd.load_win) ptr <= search_start[PageBits-1:0];
      else if (cmd.ptr_base) ptr <= base_ptr;
      else if (cmd.step || cmd.alloc_wr || cmd.mem_clr) ptr <= ptr + 1'b1;

      if (cmd.load || cmd.reset_run || cmd.ptr_base) idx <= '0;
      else if (cmd.step || cmd.alloc_wr) idx <= idx + 1'b1;

      if (cmd.load || cmd.reset_run) run <= '0;
      else if (cmd.step && r.op == OP_ALLOC) begin
        run <= rdata[B_PRESENT] ? '0 : run + 1'b1;
      end

      if (cmd.load || cmd.reset_run) done <= '0;
      else if (cmd.step && r.op != OP_ALLOC) begin
        if (r.op != OP_FREE || rdata[B_PRESENT]) done <= done + 1'b1;
      end

      if (cmd.load) base <= req.start_page;
      else if (cmd.step && auto_alloc && !rdata[B_PRESENT] &&
               (run + 1'b1 == r.page_count)) base <= hit_base;

      if (cmd.load_win) wptr <= search_start[PageBits:0];
      else if (cmd.step && r.op == OP_ALLOC) wptr <= wptr + 1'b1;

      if (cmd.commit) begin
        rsp  <= rsp_next;
        used <= used_next;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.op         = r.op;
    sts.range_ok   = (r.page_count != '0) && (range_end <= (PageBits+2)'(TablePages));
    sts.start_zero = (r.start_page == '0);
    sts.cnt_zero   = (r.page_count == '0);
    sts.quota_fail = (r.page_count > avail);
    sts.win_empty  = (search_start >= win_end);
    sts.win_last   = ((CntBits'(wptr) + 1'b1) >= win_end);
    sts.cnt_last   = (idx + 1'b1 == r.page_count);
    sts.present    = rdata[B_PRESENT];
    sts.guard      = rdata[3];
    sts.fault      = fault;
    sts.run_hit    = !rdata[B_PRESENT] && (run + 1'b1 == r.page_count);
    sts.done_zero  = (done == '0);
    sts.alloc_last = (idx + 1'b1 == r.page_count);
    sts.clr_last   = (ptr == '1);
  end

endmodule

### src/ppt_ctrl.sv
module ppt_ctrl
  import ppt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic [3:0] res_status
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_READ   = 9'b000001000,
    S_EVAL   = 9'b000010000,
    S_PROT2  = 9'b000100000,
    S_ALLOCW = 9'b001000000,
    S_COMMIT = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [3:0] stat, stat_next;
  logic       phase2, phase2_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign res_status = stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      stat   <= '0;
      phase2 <= 1'b0;
    end else begin
      state  <= state_next;
      stat   <= stat_next;
      phase2 <= phase2_next;
    end
  end

  always_comb begin
    state_next  = state;
    stat_next   = stat;
    phase2_next = phase2;
    cmd         = '0;
    case (state)
      S_CLEAR: begin
        cmd.mem_clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          stat_next   = ST_OK;
          phase2_next = 1'b0;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_READ;
        case (sts.op)
          OP_ALLOC: begin
            if (sts.cnt_zero) begin
              stat_next = ST_BAD_RANGE; state_next = S_COMMIT;
            end else if (sts.quota_fail) begin
              stat_next = ST_NO_SPACE; state_next = S_COMMIT;
            end else if (sts.start_zero) begin
              if (sts.win_empty) begin
                stat_next = ST_NO_SPACE; state_next = S_COMMIT;
              end else cmd.load_win = 1'b1;
            end else if (!sts.range_ok) begin
              stat_next = ST_BAD_RANGE; state_next = S_COMMIT;
            end
          end
          OP_FREE, OP_PROTECT, OP_READ, OP_WRITE, OP_FETCH: begin
            if (!sts.range_ok) begin
              stat_next = ST_BAD_RANGE; state_next = S_COMMIT;
            end
          end
          OP_QUERY: ;
          default: begin
            stat_next = ST_BAD_RANGE; state_next = S_COMMIT;
          end
        endcase
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_READ;
        case (sts.op)
          OP_QUERY: state_next = S_COMMIT;
          OP_ALLOC: begin
            cmd.step = 1'b1;
            if (sts.start_zero) begin
              if (sts.run_hit) state_next = S_ALLOCW;
              else if (sts.win_last) begin
                stat_next = ST_NO_SPACE; state_next = S_COMMIT;
              end
            end else if (sts.present) begin
              stat_next = ST_OVERLAP; state_next = S_COMMIT;
            end else if (sts.cnt_last) state_next = S_ALLOCW;
            if (state_next == S_ALLOCW) cmd.ptr_base = 1'b1;
          end
          OP_FREE: begin
            cmd.step    = 1'b1;
            cmd.wr_back = 1'b1;
            if (sts.cnt_last) begin
              state_next = S_COMMIT;
              if (sts.done_zero && !sts.present) stat_next = ST_NONE_FREED;
            end
          end
          OP_PROTECT: begin
            if (!phase2) begin
              cmd.step = 1'b1;
              if (!sts.present) begin
                stat_next = ST_NOT_PRESENT; state_next = S_COMMIT;
              end else if (sts.cnt_last) state_next = S_PROT2;
            end else begin
              cmd.step    = 1'b1;
              cmd.wr_back = 1'b1;
              if (sts.cnt_last) state_next = S_COMMIT;
            end
          end
          default: begin
            if (sts.fault) begin
              state_next = S_COMMIT;
              if (sts.op == OP_FETCH && !sts.done_zero) stat_next = ST_OK;
              else if (!sts.present) stat_next = ST_NOT_PRESENT;
              else if (sts.guard) stat_next = ST_GUARD;
              else if (sts.op == OP_READ) stat_next = ST_READ_VIOL;
              else if (sts.op == OP_WRITE) stat_next = ST_WRITE_VIOL;
              else stat_next = ST_EXEC_VIOL;
            end else begin
              cmd.step    = 1'b1;
              cmd.wr_back = 1'b1;
              if (sts.cnt_last) state_next = S_COMMIT;
            end
          end
        endcase
      end
      S_PROT2: begin
        cmd.load       = 1'b0;
        cmd.reset_run  = 1'b1;
        cmd.ptr_base   = 1'b1;
        phase2_next    = 1'b1;
        state_next     = S_READ;
      end
      S_ALLOCW: begin
        cmd.alloc_wr = 1'b1;
        if (sts.alloc_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/page_protection_table_top.sv
// Channel   Direction  Payload  Handshake
// req       in         req_t    req_valid / req_stall
// rsp       out        rsp_t    rsp_valid / rsp_stall
// cfg       in         21 bits  cfg_we, cfg_index
// An accepted request is range checked and, unless the check fails, walks its pages
// with a read and an evaluate step per page, then goes through commit and response.
// Explicit allocation adds a write pass over the n pages; protect adds a pointer reset and a second walk.
// Automatic placement scans window pages for a free run, then writes the n pages.
// After reset a clearing pass over all 2^20 entries runs before the first request is taken.
// A stalled response holds the block in its response state, so requests stall as well.
module page_protection_table_top
  import ppt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CntBits-1:0] cfg_data
);

  cmd_t       cmd;
  sts_t       sts;
  logic [3:0] res_status;

  ppt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req_valid),
    .in_stall   (req_stall),
    .out_valid  (rsp_valid),
    .out_stall  (rsp_stall),
    .sts        (sts),
    .cmd        (cmd),
    .res_status (res_status)
  );

  ppt_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req),
    .cmd        (cmd),
    .res_status (res_status),
    .sts        (sts),
    .rsp        (rsp)
  );

endmodule
